// ===== design/der_rs_pkg.sv =====
package der_rs_pkg;

    localparam logic       OP_PUSH = 1'b0;
    localparam logic       OP_READ = 1'b1;

    localparam logic       SEL_R = 1'b0;
    localparam logic       SEL_S = 1'b1;

    localparam logic [7:0] TAG_SEQUENCE = 8'h30;
    localparam logic [7:0] TAG_INTEGER  = 8'h02;
    localparam logic [7:0] LEN_LONG_BIT = 8'h80;
    localparam logic [7:0] LEN_COUNT    = 8'h7F;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_PARSE = 2'd1;
    localparam logic [1:0] ST_DONE  = 2'd2;
    localparam logic [1:0] ST_ERROR = 2'd3;

    localparam logic [1:0] CURVE_P256 = 2'd0;
    localparam logic [1:0] CURVE_P384 = 2'd1;
    localparam logic [1:0] CURVE_P521 = 2'd2;

    localparam logic [6:0] BYTES_P256 = 7'd32;
    localparam logic [6:0] BYTES_P384 = 7'd48;
    localparam logic [6:0] BYTES_P521 = 7'd66;

    typedef struct packed {
        logic [1:0] status;
        logic       rd_ok;
    } t_step_res;

    function automatic logic [6:0] curve_bytes(input logic [1:0] kind);
        logic [6:0] len;
        case (kind)
            CURVE_P256: len = BYTES_P256;
            CURVE_P384: len = BYTES_P384;
            CURVE_P521: len = BYTES_P521;
            default:    len = 7'd0;
        endcase
        return len;
    endfunction

endpackage

// ===== design/der_ecdsa_signature_to_rs.sv =====
// A transaction's result passes through a read stage and then an output register before it appears.
// Throughput: one transaction per cycle, push or read, while o_stall is low; the value
// store has one write port for pushes and one registered read port for reads.
// Reset (i_rst_n, synchronous, active low) returns the parser to idle, curve
// kind to P-256 and empties the pipeline; the value store itself is not cleared.
module der_ecdsa_signature_to_rs
    import der_rs_pkg::*;
#(
    parameter int MAX_VALUE_BYTES = 66
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_wdata,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic       i_op,
    input  logic       i_start_req,
    input  logic [7:0] i_byte_in,
    input  logic       i_read_which,
    input  logic [6:0] i_read_index,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [1:0] o_status,
    output logic [7:0] o_read_data
);

    localparam int DEPTH = 2 * MAX_VALUE_BYTES;
    localparam int AW    = $clog2(DEPTH);

    logic [1:0]    r_curve_kind;
    logic          r_a_valid;
    t_step_res     r_a_res;
    logic          r_o_valid;
    logic [1:0]    r_o_status;
    logic [7:0]    r_o_data;

    logic          accept, b_ready;
    logic          wr_en, rd_en;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [7:0]    rd_data;
    t_step_res     step_res;

    assign b_ready = !r_o_valid || !i_stall;
    assign o_stall = r_a_valid && !b_ready;
    assign accept  = i_valid && !o_stall;

    der_rs_parser #(
        .MAX_VALUE_BYTES(MAX_VALUE_BYTES)
    ) u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_op         (i_op),
        .i_start_req  (i_start_req),
        .i_byte_in    (i_byte_in),
        .i_read_which (i_read_which),
        .i_read_index (i_read_index),
        .i_curve_kind (r_curve_kind),
        .o_wr_en      (wr_en),
        .o_wr_addr    (wr_addr),
        .o_rd_en      (rd_en),
        .o_rd_addr    (rd_addr),
        .o_res        (step_res)
    );

    der_rs_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (i_byte_in),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_curve_kind <= CURVE_P256;
            r_a_valid    <= 1'b0;
            r_o_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_curve_kind <= i_cfg_wdata;
            end
            if (accept) begin
                r_a_valid <= 1'b1;
            end else if (b_ready) begin
                r_a_valid <= 1'b0;
            end
            if (b_ready) begin
                r_o_valid <= r_a_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_res <= step_res;
        end
        if (b_ready && r_a_valid) begin
            r_o_status <= r_a_res.status;
            r_o_data   <= r_a_res.rd_ok ? rd_data : 8'd0;
        end
    end

    assign o_valid     = r_o_valid;
    assign o_status    = r_o_status;
    assign o_read_data = r_o_data;

    a_accept_fills_stage : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_a_valid)
        else $error("accepted transaction did not enter the read stage");

    a_stall_cause : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_a_valid && r_o_valid && i_stall))
        else $error("input stalled without a blocked output");

    a_port_exclusive : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(wr_en && rd_en))
        else $error("store written and read by one transaction");

    a_idle_reads_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_IDLE) |-> (o_read_data == 8'd0))
        else $error("read before any signature returned data");

endmodule

// ===== design/der_rs_ram.sv =====
module der_rs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 132
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/der_rs_parser.sv =====
module der_rs_parser
    import der_rs_pkg::*;
#(
    parameter int MAX_VALUE_BYTES = 66
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_accept,
    input  logic                                 i_op,
    input  logic                                 i_start_req,
    input  logic [7:0]                           i_byte_in,
    input  logic                                 i_read_which,
    input  logic [6:0]                           i_read_index,
    input  logic [1:0]                           i_curve_kind,
    output logic                                 o_wr_en,
    output logic [$clog2(2*MAX_VALUE_BYTES)-1:0] o_wr_addr,
    output logic                                 o_rd_en,
    output logic [$clog2(2*MAX_VALUE_BYTES)-1:0] o_rd_addr,
    output t_step_res                            o_res
);

    localparam int AW = $clog2(2*MAX_VALUE_BYTES);
    localparam logic [AW-1:0] S_BASE = AW'(MAX_VALUE_BYTES);
    localparam logic [7:0]    MAX_B  = 8'(MAX_VALUE_BYTES);

    typedef enum logic [3:0] {
        P_IDLE, P_SEQ_LEN, P_SEQ_MORE, P_R_TAG, P_R_LEN, P_R_MORE, P_R_DATA,
        P_S_TAG, P_S_LEN, P_S_MORE, P_S_DATA, P_DONE, P_ERROR
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [31:0] r_accum, n_accum;
    logic [2:0]  r_left, n_left;
    logic [6:0]  r_content, n_content;
    logic        r_strip, n_strip;
    logic [6:0]  r_off_r, n_off_r, r_off_s, n_off_s;
    logic [6:0]  r_fill_r, n_fill_r, r_fill_s, n_fill_s;
    logic [6:0]  r_vlen, n_vlen;

    logic [31:0] len_val, len_trim;
    logic        len_strip, len_err, len_fin, is_s_len;
    logic [6:0]  cbytes, fill_cur, rd_off, rd_fill, new_off;
    logic [2:0]  lcount;
    logic        lform_ok;

    always_comb begin
        n_phase   = r_phase;
        n_accum   = r_accum;
        n_left    = r_left;
        n_content = r_content;
        n_strip   = r_strip;
        n_off_r   = r_off_r;
        n_off_s   = r_off_s;
        n_fill_r  = r_fill_r;
        n_fill_s  = r_fill_s;
        n_vlen    = r_vlen;
        o_wr_en   = 1'b0;
        len_fin   = 1'b0;

        len_val   = (r_phase == P_SEQ_MORE || r_phase == P_R_MORE || r_phase == P_S_MORE) ?
                    {r_accum[23:0], i_byte_in} : {24'd0, i_byte_in};
        len_strip = len_val > {25'd0, r_vlen};
        len_trim  = len_val - {31'd0, len_strip};
        len_err   = len_trim > {25'd0, r_vlen};
        new_off   = r_vlen - len_trim[6:0];
        is_s_len  = (r_phase == P_S_LEN || r_phase == P_S_MORE);

        lcount    = i_byte_in[2:0];
        lform_ok  = ((i_byte_in & LEN_COUNT) >> 3) == 8'd0 && lcount != 3'd0
                    && lcount <= 3'd4;
        cbytes    = curve_bytes(i_curve_kind);
        fill_cur  = (r_phase == P_S_DATA) ? r_fill_s : r_fill_r;
        o_wr_addr = AW'(fill_cur) + ((r_phase == P_S_DATA) ? S_BASE : AW'(0));

        if (i_accept && i_op == OP_PUSH) begin
            if (i_start_req) begin
                n_accum   = 32'd0;
                n_left    = 3'd0;
                n_content = 7'd0;
                n_strip   = 1'b0;
                if (cbytes == 7'd0 || {1'b0, cbytes} > MAX_B || i_byte_in != TAG_SEQUENCE) begin
                    n_phase = P_ERROR;
                end else begin
                    n_vlen  = cbytes;
                    n_phase = P_SEQ_LEN;
                end
            end else begin
                unique case (r_phase)
                    P_SEQ_LEN, P_R_LEN, P_S_LEN: begin
                        if ((i_byte_in & LEN_LONG_BIT) == 8'd0) begin
                            n_accum = len_val;
                            len_fin = 1'b1;
                        end else if (!lform_ok) begin
                            n_phase = P_ERROR;
                        end else begin
                            n_accum = 32'd0;
                            n_left  = lcount;
                            n_phase = t_phase'(r_phase + 4'd1);
                        end
                    end
                    P_SEQ_MORE, P_R_MORE, P_S_MORE: begin
                        n_accum = len_val;
                        n_left  = r_left - {2'd0, r_left != 3'd0};
                        len_fin = (n_left == 3'd0);
                    end
                    P_R_TAG: begin
                        if (i_byte_in != TAG_INTEGER) begin
                            n_phase = P_ERROR;
                        end else begin
                            n_off_r  = 7'd0;
                            n_fill_r = 7'd0;
                            n_off_s  = 7'd0;
                            n_fill_s = 7'd0;
                            n_phase  = P_R_LEN;
                        end
                    end
                    P_S_TAG: begin
                        n_phase = (i_byte_in == TAG_INTEGER) ? P_S_LEN : P_ERROR;
                    end
                    P_R_DATA, P_S_DATA: begin
                        if (r_strip) begin
                            n_strip = 1'b0;
                        end else begin
                            o_wr_en   = ({1'b0, fill_cur} < MAX_B);
                            n_content = r_content - 7'd1;
                            if (r_phase == P_S_DATA) begin
                                n_fill_s = r_fill_s + 7'd1;
                            end else begin
                                n_fill_r = r_fill_r + 7'd1;
                            end
                            if (r_content == 7'd1) begin
                                n_phase = (r_phase == P_S_DATA) ? P_DONE : P_S_TAG;
                            end
                        end
                    end
                    default: begin
                    end
                endcase

                if (len_fin) begin
                    if (r_phase == P_SEQ_LEN || r_phase == P_SEQ_MORE) begin
                        n_phase = P_R_TAG;
                    end else if (len_err) begin
                        n_phase = P_ERROR;
                    end else begin
                        n_content = len_trim[6:0];
                        n_strip   = len_strip;
                        if (is_s_len) begin
                            n_off_s  = new_off;
                            n_fill_s = new_off;
                        end else begin
                            n_off_r  = new_off;
                            n_fill_r = new_off;
                        end
                        if (len_trim == 32'd0) begin
                            n_phase = is_s_len ? P_DONE : P_S_TAG;
                        end else begin
                            n_phase = is_s_len ? P_S_DATA : P_R_DATA;
                        end
                    end
                end
            end
        end
    end

    always_comb begin
        rd_off    = (i_read_which == SEL_S) ? r_off_s : r_off_r;
        rd_fill   = (i_read_which == SEL_S) ? r_fill_s : r_fill_r;
        o_rd_en   = i_accept && i_op == OP_READ;
        o_rd_addr = AW'(i_read_index) + ((i_read_which == SEL_S) ? S_BASE : AW'(0));
        o_res.rd_ok = (i_op == OP_READ) && !(i_read_index < rd_off
                      || i_read_index >= rd_fill || i_read_index >= r_vlen
                      || {1'b0, i_read_index} >= MAX_B);
        unique case (n_phase)
            P_IDLE:  o_res.status = ST_IDLE;
            P_DONE:  o_res.status = ST_DONE;
            P_ERROR: o_res.status = ST_ERROR;
            default: o_res.status = ST_PARSE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= P_IDLE;
            r_accum   <= 32'd0;
            r_left    <= 3'd0;
            r_content <= 7'd0;
            r_strip   <= 1'b0;
            r_off_r   <= 7'd0;
            r_off_s   <= 7'd0;
            r_fill_r  <= 7'd0;
            r_fill_s  <= 7'd0;
            r_vlen    <= BYTES_P256;
        end else begin
            r_phase   <= n_phase;
            r_accum   <= n_accum;
            r_left    <= n_left;
            r_content <= n_content;
            r_strip   <= n_strip;
            r_off_r   <= n_off_r;
            r_off_s   <= n_off_s;
            r_fill_r  <= n_fill_r;
            r_fill_s  <= n_fill_s;
            r_vlen    <= n_vlen;
        end
    end

endmodule
